[sv/sha_pkg.sv]
package sha_pkg;

  localparam int unsigned ADDR_BITS    = 16;
  localparam int unsigned ALIGN_BYTES  = 16;
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned HDR_DEPTH    = 4096;
  localparam int unsigned HDR_AW       = $clog2(HDR_DEPTH);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_RESIZE  = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOMEM   = 2'd2
  } status_e;

  typedef struct packed {
    logic [ADDR_BITS-1:0] used;
    logic [ADDR_BITS-1:0] cap;
    logic [ADDR_BITS-1:0] prev;
  } hdr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALC_CHK,
    S_ALC_WR,
    S_LNK_RD,
    S_LNK_WR,
    S_REL_RD,
    S_REL_MARK,
    S_REL_TOP,
    S_REL_PREV,
    S_REL_CHK,
    S_RSZ_RD,
    S_RSZ_HDR,
    S_RSZ_TOP,
    S_RSZ_WR,
    S_DONE
  } state_e;

  // header slot of a frame address: (a / align) mod depth
  function automatic logic [HDR_AW-1:0] slot_of(input logic [ADDR_BITS-1:0] a,
                                                input int unsigned sh);
    logic [31:0] t;
    t = 32'(a) >> sh;
    return t[HDR_AW-1:0];
  endfunction

endpackage

[sv/sha_ram.sv]
module sha_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/stack_heap_allocator.sv]
// Bump heap allocator over a chain of frames. Each frame header (used, capacity,
// previous frame) lives in a 4096-entry header RAM, addressed by frame address
// divided by the alignment. start is taken when busy is low; busy then stays
// high until the one result is shown on the result ports with done_o high for a
// single cycle, which the receiver must take as it comes. Each command runs as a
// read-modify-write sequence on the one-read one-write header RAM: allocate checks
// the request, writes the header of the top frame, then reads and writes the link
// of the new top; release marks its frame unused and pops each unused frame off
// the top (at most 4096); an in-place resize reads and rewrites the header and
// trims the top when the block is the last frame; a moving resize allocates and
// then releases; the trivial cases (null, zero size, unused command) go to done.
// heap_base may be written only while busy is low; it also empties the heap.
module stack_heap_allocator #(
  parameter int unsigned ALIGN_BYTES  = sha_pkg::ALIGN_BYTES,
  parameter int unsigned HEADER_BYTES = sha_pkg::HEADER_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        heap_base_we_i,
  input  logic [15:0] heap_base_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [15:0] block_address_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] stack_limit_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] result_address_o,
  output logic [15:0] copy_source_o,
  output logic [15:0] copy_length_o
);

  localparam int unsigned SH  = $clog2(ALIGN_BYTES);
  localparam int unsigned AW  = sha_pkg::ADDR_BITS;
  localparam int unsigned EW  = AW + 2;             // room for payload end and round-up
  localparam int unsigned CW  = sha_pkg::HDR_AW + 1; // pop counter reaches the depth
  localparam logic [EW-1:0] AMASK_E = EW'((1 << AW) - 1);
  localparam logic [EW-1:0] ALN_M1  = EW'(ALIGN_BYTES - 1);

  sha_pkg::state_e state_q, state_d;

  // control and item registers
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] top_q, top_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] size_q, size_d;
  logic [AW-1:0] limit_q, limit_d;
  logic          move_q, move_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // scratch and result registers
  logic [AW-1:0]       nt_q, nt_d;
  logic [AW-1:0]       cap_q, cap_d;
  logic [AW-1:0]       lnk_addr_q, lnk_addr_d;
  logic [AW-1:0]       lnk_prev_q, lnk_prev_d;
  logic [AW-1:0]       pop_q, pop_d;
  logic [AW-1:0]       oldlen_q, oldlen_d;
  logic                trim_q, trim_d;
  sha_pkg::hdr_t       h_q, h_d;
  logic [1:0]          status_q, status_d;
  logic [AW-1:0]       res_q, res_d;
  logic [AW-1:0]       csrc_q, csrc_d;
  logic [AW-1:0]       clen_q, clen_d;

  // header RAM ports
  logic                      ram_we, ram_re;
  logic [sha_pkg::HDR_AW-1:0] ram_waddr, ram_raddr;
  sha_pkg::hdr_t             ram_wdata, ram_rdata;

  // allocate arithmetic on the current top frame
  logic [EW-1:0] obj_e, end_e, nt_e;
  logic          alc_bad, alc_nomem;
  // in-place resize arithmetic
  logic [EW-1:0] rend_e, rnt_e;
  logic [AW-1:0] rnt, rcap, rframe;
  logic          accept;

  assign accept  = start && (state_q == sha_pkg::S_IDLE);
  assign obj_e   = EW'(top_q) + EW'(HEADER_BYTES);
  assign end_e   = obj_e + EW'(size_q);
  assign nt_e    = (end_e + ALN_M1) & ~ALN_M1;
  assign alc_bad   = (size_q == '0) || (end_e > AMASK_E);
  assign alc_nomem = nt_e > EW'(limit_q);

  assign rframe = ptr_q - AW'(HEADER_BYTES);
  assign rend_e = EW'(ptr_q) + EW'(size_q);
  assign rnt_e  = (rend_e + ALN_M1) & ~ALN_M1;
  assign rnt    = rnt_e[AW-1:0];
  assign rcap   = rnt - ptr_q;

  sha_ram #(
    .WIDTH($bits(sha_pkg::hdr_t)),
    .DEPTH(sha_pkg::HDR_DEPTH)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sha_pkg::S_IDLE: begin
        if (accept) begin
          case (sha_pkg::cmd_e'(command_i))
            sha_pkg::CMD_ALLOC: state_d = sha_pkg::S_ALC_CHK;
            sha_pkg::CMD_RELEASE: begin
              state_d = (block_address_i == '0) ? sha_pkg::S_DONE : sha_pkg::S_REL_RD;
            end
            sha_pkg::CMD_RESIZE: begin
              if (block_address_i == '0) begin
                state_d = (request_size_i != '0) ? sha_pkg::S_ALC_CHK : sha_pkg::S_DONE;
              end else if (request_size_i == '0) begin
                state_d = sha_pkg::S_DONE;
              end else begin
                state_d = sha_pkg::S_RSZ_RD;
              end
            end
            default: state_d = sha_pkg::S_DONE;
          endcase
        end
      end
      sha_pkg::S_ALC_CHK: begin
        state_d = (alc_bad || alc_nomem) ? sha_pkg::S_DONE : sha_pkg::S_ALC_WR;
      end
      sha_pkg::S_ALC_WR: state_d = sha_pkg::S_LNK_RD;
      sha_pkg::S_LNK_RD: state_d = sha_pkg::S_LNK_WR;
      sha_pkg::S_LNK_WR: state_d = move_q ? sha_pkg::S_REL_RD : sha_pkg::S_DONE;
      sha_pkg::S_REL_RD: state_d = sha_pkg::S_REL_MARK;
      sha_pkg::S_REL_MARK: state_d = sha_pkg::S_REL_TOP;
      sha_pkg::S_REL_TOP: begin
        if (top_q == base_q || cnt_q == CW'(sha_pkg::HDR_DEPTH)) begin
          state_d = sha_pkg::S_DONE;
        end else begin
          state_d = sha_pkg::S_REL_PREV;
        end
      end
      sha_pkg::S_REL_PREV: state_d = sha_pkg::S_REL_CHK;
      sha_pkg::S_REL_CHK: begin
        state_d = (ram_rdata.used != '0) ? sha_pkg::S_DONE : sha_pkg::S_REL_TOP;
      end
      sha_pkg::S_RSZ_RD: state_d = sha_pkg::S_RSZ_HDR;
      sha_pkg::S_RSZ_HDR: begin
        if (size_q > ram_rdata.cap) begin
          state_d = sha_pkg::S_ALC_CHK;
        end else if (top_q != base_q) begin
          state_d = sha_pkg::S_RSZ_TOP;
        end else begin
          state_d = sha_pkg::S_RSZ_WR;
        end
      end
      sha_pkg::S_RSZ_TOP: state_d = sha_pkg::S_RSZ_WR;
      sha_pkg::S_RSZ_WR: state_d = trim_q ? sha_pkg::S_LNK_RD : sha_pkg::S_DONE;
      sha_pkg::S_DONE: state_d = sha_pkg::S_IDLE;
      default: state_d = sha_pkg::S_IDLE;
    endcase
  end

  // datapath and header RAM control
  always_comb begin
    base_d     = base_q;
    top_d      = top_q;
    ptr_d      = ptr_q;
    size_d     = size_q;
    limit_d    = limit_q;
    move_d     = move_q;
    cnt_d      = cnt_q;
    nt_d       = nt_q;
    cap_d      = cap_q;
    lnk_addr_d = lnk_addr_q;
    lnk_prev_d = lnk_prev_q;
    pop_d      = pop_q;
    oldlen_d   = oldlen_q;
    trim_d     = trim_q;
    h_d        = h_q;
    status_d   = status_q;
    res_d      = res_q;
    csrc_d     = csrc_q;
    clen_d     = clen_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = sha_pkg::slot_of(top_q, SH);
    ram_raddr  = sha_pkg::slot_of(top_q, SH);
    ram_wdata  = ram_rdata;

    case (state_q)
      sha_pkg::S_IDLE: begin
        if (heap_base_we_i) begin
          base_d = heap_base_i;
          top_d  = heap_base_i;
        end
        if (accept) begin
          ptr_d    = block_address_i;
          size_d   = request_size_i;
          limit_d  = stack_limit_i;
          move_d   = 1'b0;
          trim_d   = 1'b0;
          res_d    = '0;
          csrc_d   = '0;
          clen_d   = '0;
          status_d = sha_pkg::ST_OK;
          // unused command, and resize to zero of a live block
          if (sha_pkg::cmd_e'(command_i) == sha_pkg::CMD_UNUSED ||
              (sha_pkg::cmd_e'(command_i) == sha_pkg::CMD_RESIZE &&
               block_address_i != '0 && request_size_i == '0)) begin
            status_d = sha_pkg::ST_INVALID;
          end
        end
      end
      sha_pkg::S_ALC_CHK: begin
        if (alc_bad) begin
          status_d = sha_pkg::ST_INVALID;
        end else if (alc_nomem) begin
          status_d = sha_pkg::ST_NOMEM;
        end else begin
          ram_re = 1'b1;
          nt_d   = nt_e[AW-1:0];
          cap_d  = AW'(nt_e - obj_e);
        end
      end
      sha_pkg::S_ALC_WR: begin
        ram_we          = 1'b1;
        ram_wdata.used  = size_q;
        ram_wdata.cap   = cap_q;
        lnk_addr_d      = nt_q;
        lnk_prev_d      = top_q;
        res_d           = obj_e[AW-1:0];
      end
      sha_pkg::S_LNK_RD: begin
        ram_re    = 1'b1;
        ram_raddr = sha_pkg::slot_of(lnk_addr_q, SH);
      end
      sha_pkg::S_LNK_WR: begin
        ram_we         = 1'b1;
        ram_waddr      = sha_pkg::slot_of(lnk_addr_q, SH);
        ram_wdata.prev = lnk_prev_q;
        top_d          = lnk_addr_q;
        if (move_q) begin
          csrc_d = ptr_q;
          clen_d = oldlen_q;
        end
      end
      sha_pkg::S_REL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = sha_pkg::slot_of(rframe, SH);
      end
      sha_pkg::S_REL_MARK: begin
        ram_we         = 1'b1;
        ram_waddr      = sha_pkg::slot_of(rframe, SH);
        ram_wdata.used = '0;
        cnt_d          = '0;
      end
      sha_pkg::S_REL_TOP: begin
        ram_re = 1'b1;
      end
      sha_pkg::S_REL_PREV: begin
        // look at the frame below the top
        ram_re    = 1'b1;
        ram_raddr = sha_pkg::slot_of(ram_rdata.prev, SH);
        pop_d     = ram_rdata.prev;
      end
      sha_pkg::S_REL_CHK: begin
        if (ram_rdata.used == '0) begin
          top_d = pop_q;
          cnt_d = cnt_q + 1'b1;
        end
      end
      sha_pkg::S_RSZ_RD: begin
        ram_re    = 1'b1;
        ram_raddr = sha_pkg::slot_of(rframe, SH);
      end
      sha_pkg::S_RSZ_HDR: begin
        h_d      = ram_rdata;
        oldlen_d = ram_rdata.used;
        trim_d   = 1'b0;
        ram_re   = 1'b1;
        if (size_q > ram_rdata.cap) begin
          move_d = 1'b1;
        end
      end
      sha_pkg::S_RSZ_TOP: begin
        // block is the top one when the top frame links back to it
        trim_d = (ram_rdata.prev == rframe);
      end
      sha_pkg::S_RSZ_WR: begin
        ram_we         = 1'b1;
        ram_waddr      = sha_pkg::slot_of(rframe, SH);
        ram_wdata.used = size_q;
        ram_wdata.cap  = trim_q ? rcap : h_q.cap;
        ram_wdata.prev = h_q.prev;
        res_d          = ptr_q;
        lnk_addr_d     = rnt;
        lnk_prev_d     = rframe;
      end
      sha_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::S_IDLE;
      base_q  <= '0;
      top_q   <= '0;
      move_q  <= 1'b0;
      trim_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      top_q   <= top_d;
      move_q  <= move_d;
      trim_q  <= trim_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    size_q     <= size_d;
    limit_q    <= limit_d;
    nt_q       <= nt_d;
    cap_q      <= cap_d;
    lnk_addr_q <= lnk_addr_d;
    lnk_prev_q <= lnk_prev_d;
    pop_q      <= pop_d;
    oldlen_q   <= oldlen_d;
    h_q        <= h_d;
    status_q   <= status_d;
    res_q      <= res_d;
    csrc_q     <= csrc_d;
    clen_q     <= clen_d;
  end

  assign busy             = (state_q != sha_pkg::S_IDLE);
  assign done_o           = (state_q == sha_pkg::S_DONE);
  assign status_o         = status_q;
  assign result_address_o = res_q;
  assign copy_source_o    = csrc_q;
  assign copy_length_o    = clen_q;

endmodule

[sv/sha_checker.sv]
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [15:0] result_address_o,
  input logic [15:0] copy_source_o,
  input logic [15:0] copy_length_o
);

  // a taken item keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("item taken without busy");

  // the result strobe only while working, and single cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result outside an item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

  // refusals give nothing back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != sha_pkg::ST_OK |->
      result_address_o == '0 && copy_length_o == '0 && copy_source_o == '0)
    else $error("refused item returned an address");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o == sha_pkg::ST_OK || status_o == sha_pkg::ST_INVALID ||
               status_o == sha_pkg::ST_NOMEM)
    else $error("unknown status code");

endmodule

bind stack_heap_allocator sha_checker u_sha_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .result_address_o(result_address_o),
  .copy_source_o   (copy_source_o),
  .copy_length_o   (copy_length_o)
);

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_CYCLES = 60000;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned AMASK           = 32'h0000_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        heap_base_we_i = 1'b0;
  logic [15:0] heap_base_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = sha_pkg::CMD_ALLOC;
  logic [15:0] block_address_i = '0;
  logic [15:0] request_size_i = '0;
  logic [15:0] stack_limit_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] result_address_o;
  logic [15:0] copy_source_o;
  logic [15:0] copy_length_o;

  stack_heap_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .heap_base_we_i  (heap_base_we_i),
    .heap_base_i     (heap_base_i),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .block_address_i (block_address_i),
    .request_size_i  (request_size_i),
    .stack_limit_i   (stack_limit_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .result_address_o(result_address_o),
    .copy_source_o   (copy_source_o),
    .copy_length_o   (copy_length_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // one result as the block reports it
  typedef struct {
    sha_pkg::status_e st;
    logic [15:0]      addr;
    logic [15:0]      src;
    logic [15:0]      len;
  } outcome_t;

  // directed stimulus row; use_last picks the newest live block as address
  typedef struct {
    sha_pkg::cmd_e    cmd;
    bit               use_last;
    logic [15:0]      addr;
    logic [15:0]      size;
    logic [15:0]      limit;
    bit               typed;
    sha_pkg::status_e st;
    logic [15:0]      res;
  } row_t;

  outcome_t    pending_q[$];
  logic [15:0] live_q[$];     // payloads handed out and not yet released
  row_t        rows[$];
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  int unsigned quiet_cycles = 0;

  // heap model state
  int unsigned base_m, top_m;
  int unsigned used_m[sha_pkg::HDR_DEPTH];
  int unsigned cap_m[sha_pkg::HDR_DEPTH];
  int unsigned prev_m[sha_pkg::HDR_DEPTH];

  function automatic int unsigned hdr_slot(int unsigned a);
    return (a / sha_pkg::ALIGN_BYTES) % sha_pkg::HDR_DEPTH;
  endfunction

  function automatic int unsigned align_up(int unsigned v);
    return ((v + sha_pkg::ALIGN_BYTES - 1) / sha_pkg::ALIGN_BYTES) * sha_pkg::ALIGN_BYTES;
  endfunction

  function automatic sha_pkg::status_e heap_grow(int unsigned size, int unsigned limit,
                                                 output int unsigned res);
    int unsigned obj, fin, nt;
    res = 0;
    obj = top_m + sha_pkg::HEADER_BYTES;
    fin = obj + size;
    if (size == 0 || fin > AMASK) return sha_pkg::ST_INVALID;
    nt = align_up(fin);
    if (nt > limit) return sha_pkg::ST_NOMEM;
    used_m[hdr_slot(top_m)] = size;
    cap_m[hdr_slot(top_m)]  = nt - obj;
    prev_m[hdr_slot(nt)]    = top_m;
    top_m = nt;
    res = obj;
    return sha_pkg::ST_OK;
  endfunction

  function automatic void heap_drop(int unsigned ptr);
    int unsigned p;
    if (ptr == 0) return;
    used_m[hdr_slot((ptr - sha_pkg::HEADER_BYTES) & AMASK)] = 0;
    // pop unused frames off the top
    for (int unsigned n = 0; n < sha_pkg::HDR_DEPTH; n++) begin
      if (top_m == base_m) break;
      p = prev_m[hdr_slot(top_m)];
      if (used_m[hdr_slot(p)] != 0) break;
      top_m = p;
    end
  endfunction

  function automatic outcome_t heap_predict(sha_pkg::cmd_e cmd, int unsigned ptr,
                                            int unsigned size, int unsigned limit);
    outcome_t    o;
    int unsigned r, s, res, old_len, nt;
    o = '{sha_pkg::ST_OK, 16'd0, 16'd0, 16'd0};
    res = 0;
    case (cmd)
      sha_pkg::CMD_ALLOC: o.st = heap_grow(size, limit, res);
      sha_pkg::CMD_RELEASE: heap_drop(ptr);
      sha_pkg::CMD_RESIZE: begin
        if (ptr == 0) begin
          if (size != 0) o.st = heap_grow(size, limit, res);
        end else if (size == 0) begin
          o.st = sha_pkg::ST_INVALID;
        end else begin
          r = (ptr - sha_pkg::HEADER_BYTES) & AMASK;
          s = hdr_slot(r);
          if (size <= cap_m[s]) begin
            used_m[s] = size;
            // block just below the top: trim the top to the new end
            if (top_m != base_m && prev_m[hdr_slot(top_m)] == r) begin
              nt = align_up(ptr + size) & AMASK;
              cap_m[s] = (nt - ptr) & AMASK;
              prev_m[hdr_slot(nt)] = r;
              top_m = nt;
            end
            res = ptr;
          end else begin
            old_len = used_m[s];
            o.st = heap_grow(size, limit, res);
            if (o.st == sha_pkg::ST_OK) begin
              o.src = 16'(ptr);
              o.len = 16'(old_len);
              heap_drop(ptr);
            end
          end
        end
      end
      default: o.st = sha_pkg::ST_INVALID;
    endcase
    o.addr = 16'(res);
    return o;
  endfunction

  function automatic void track_live(sha_pkg::cmd_e cmd, logic [15:0] ptr, outcome_t o);
    if (cmd == sha_pkg::CMD_RELEASE ||
        (cmd == sha_pkg::CMD_RESIZE && o.len != 0 && o.src == ptr)) begin
      foreach (live_q[i]) if (live_q[i] == ptr) begin
        live_q.delete(i);
        break;
      end
    end
    if ((cmd == sha_pkg::CMD_ALLOC || cmd == sha_pkg::CMD_RESIZE) &&
        o.st == sha_pkg::ST_OK && o.addr != 0 && o.addr != ptr)
      live_q.push_back(o.addr);
  endfunction

  // one item: drive, wait for acceptance, then predict
  task automatic issue(sha_pkg::cmd_e cmd, logic [15:0] ptr, logic [15:0] size,
                       logic [15:0] limit, bit typed, sha_pkg::status_e st,
                       logic [15:0] res);
    outcome_t o;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    command_i       <= cmd;
    block_address_i <= ptr;
    request_size_i  <= size;
    stack_limit_i   <= limit;
    do @(posedge clk_i); while (busy);
    o = heap_predict(cmd, 32'(ptr), 32'(size), 32'(limit));
    track_live(cmd, ptr, o);
    if (typed) o = '{st, res, 16'd0, 16'd0};
    pending_q.push_back(o);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_base(logic [15:0] v);
    wait_idle();
    heap_base_we_i <= 1'b1;
    heap_base_i    <= v;
    @(posedge clk_i);
    heap_base_we_i <= 1'b0;
    base_m = 32'(v);
    top_m  = 32'(v);
    live_q.delete();
  endtask

  function automatic logic [15:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(64, 1));
    if (r < 90) return 16'($urandom_range(2048, 1));
    if (r < 95) return 16'd0;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task automatic random_items(int unsigned n);
    int unsigned r;
    logic [15:0] ptr, lim;
    for (int unsigned k = 0; k < n; k++) begin
      r   = $urandom_range(99);
      lim = ($urandom_range(99) < 80) ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
      ptr = 16'd0;
      if (live_q.size() != 0 && $urandom_range(99) < 88)
        ptr = live_q[$urandom_range(live_q.size() - 1)];
      if (k == n / 2) wait_idle(); // sender holds until everything is back
      if (r < 40)      issue(sha_pkg::CMD_ALLOC, 16'($urandom_range(16'hFFFF)), pick_size(),
                             lim, 1'b0, sha_pkg::ST_OK, 16'd0);
      else if (r < 68) issue(sha_pkg::CMD_RELEASE, ptr, 16'($urandom_range(16'hFFFF)), lim,
                             1'b0, sha_pkg::ST_OK, 16'd0);
      else if (r < 95) issue(sha_pkg::CMD_RESIZE, ptr, pick_size(), lim, 1'b0,
                             sha_pkg::ST_OK, 16'd0);
      else             issue(sha_pkg::CMD_UNUSED, 16'($urandom_range(16'hFFFF)),
                             16'($urandom_range(16'hFFFF)), lim, 1'b0, sha_pkg::ST_OK,
                             16'd0);
    end
  endtask

  function automatic void add_row(sha_pkg::cmd_e cmd, bit use_last, logic [15:0] addr,
                                  logic [15:0] size, logic [15:0] limit, bit typed,
                                  sha_pkg::status_e st, logic [15:0] res);
    rows.push_back('{cmd, use_last, addr, size, limit, typed, st, res});
  endfunction

  // result checker: the block cannot be held off, so every done is taken
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: st=%0d addr=%h", status_o, result_address_o);
      end else begin
        e = pending_q.pop_front();
        if (status_o !== e.st || result_address_o !== e.addr ||
            copy_source_o !== e.src || copy_length_o !== e.len) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: exp st=%0d addr=%h src=%h len=%h, ",
                      "got st=%0d addr=%h src=%h len=%h"},
                     e.st, e.addr, e.src, e.len, status_o, result_address_o,
                     copy_source_o, copy_length_o);
        end
      end
    end
  end

  // watchdog on cycles where neither an item nor a result moves
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    row_t        w;
    logic [15:0] ptr;
    base_m = 0;
    top_m  = 0;
    foreach (used_m[i]) begin
      used_m[i] = 0;
      cap_m[i]  = 0;
      prev_m[i] = 0;
    end

    // directed: refusals, null handling, in-place and moving resize
    add_row(sha_pkg::CMD_ALLOC,   0, 16'h0000, 16'd0,     16'hFFFF, 1, sha_pkg::ST_INVALID,
            16'h0000);
    add_row(sha_pkg::CMD_ALLOC,   0, 16'hFFFF, 16'hFFFF,  16'hFFFF, 1, sha_pkg::ST_INVALID,
            16'h0000);
    add_row(sha_pkg::CMD_ALLOC,   0, 16'h0000, 16'd16,    16'h0000, 1, sha_pkg::ST_NOMEM,
            16'h0000);
    add_row(sha_pkg::CMD_ALLOC,   0, 16'h0000, 16'd1,     16'hFFFF, 1, sha_pkg::ST_OK,
            16'h0020);
    add_row(sha_pkg::CMD_RELEASE, 0, 16'h0000, 16'hFFFF,  16'hFFFF, 1, sha_pkg::ST_OK,
            16'h0000);
    add_row(sha_pkg::CMD_RESIZE,  0, 16'h0000, 16'd0,     16'hFFFF, 1, sha_pkg::ST_OK,
            16'h0000);
    add_row(sha_pkg::CMD_RESIZE,  1, 16'h0000, 16'd0,     16'hFFFF, 1, sha_pkg::ST_INVALID,
            16'h0000);
    add_row(sha_pkg::CMD_UNUSED,  0, 16'hFFFF, 16'hFFFF,  16'hFFFF, 1, sha_pkg::ST_INVALID,
            16'h0000);
    add_row(sha_pkg::CMD_RESIZE,  0, 16'h0000, 16'd40,    16'hFFFF, 0, sha_pkg::ST_OK,
            16'h0000);
    add_row(sha_pkg::CMD_RESIZE,  1, 16'h0000, 16'd8,     16'hFFFF, 0, sha_pkg::ST_OK,
            16'h0000);
    add_row(sha_pkg::CMD_RESIZE,  1, 16'h0000, 16'd100,   16'hFFFF, 0, sha_pkg::ST_OK,
            16'h0000);
    add_row(sha_pkg::CMD_ALLOC,   0, 16'h0000, 16'd300,   16'hFFFF, 0, sha_pkg::ST_OK,
            16'h0000);
    add_row(sha_pkg::CMD_RESIZE,  1, 16'h0000, 16'd60000, 16'h8000, 0, sha_pkg::ST_OK,
            16'h0000);
    add_row(sha_pkg::CMD_RESIZE,  1, 16'h0000, 16'd2,     16'hFFFF, 0, sha_pkg::ST_OK,
            16'h0000);
    add_row(sha_pkg::CMD_ALLOC,   0, 16'h0000, 16'hFFBF,  16'hFFFF, 0, sha_pkg::ST_OK,
            16'h0000);
    add_row(sha_pkg::CMD_ALLOC,   0, 16'h0000, 16'd5000,  16'hFFFF, 0, sha_pkg::ST_OK,
            16'h0000);
    add_row(sha_pkg::CMD_RELEASE, 1, 16'h0000, 16'd0,     16'hFFFF, 0, sha_pkg::ST_OK,
            16'h0000);
    add_row(sha_pkg::CMD_RELEASE, 1, 16'h0000, 16'd0,     16'hFFFF, 0, sha_pkg::ST_OK,
            16'h0000);
    add_row(sha_pkg::CMD_RELEASE, 1, 16'h0000, 16'd0,     16'hFFFF, 0, sha_pkg::ST_OK,
            16'h0000);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 31;
    foreach (rows[i]) begin
      w   = rows[i];
      ptr = (w.use_last && live_q.size() != 0) ? live_q[$] : w.addr;
      issue(w.cmd, ptr, w.size, w.limit, w.typed, w.st, w.res);
    end

    // heap base at the very top: nothing fits
    set_base(16'hFFFF);
    random_items(20);
    set_base(16'h0000);
    random_items(400);

    idle_pct = 51;
    set_base(16'h4321);
    random_items(400);

    idle_pct = 0;
    set_base(16'h0FF0);
    random_items(410);

    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
sv/sha_pkg.sv
sv/sha_ram.sv
sv/stack_heap_allocator.sv
sv/sha_checker.sv
tb/tb_top.sv
